[hw/rtl/laser_line_row_detector_macros.svh]
// ----------------------------------------------------------------------------
// Laser line row detector assertion macros
// Shared concurrent assertion forms used by the RTL of the row detector.
// ----------------------------------------------------------------------------
`ifndef LASER_LINE_ROW_DETECTOR_MACROS_SVH
`define LASER_LINE_ROW_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LLRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/llrd_pkg.sv]
// ----------------------------------------------------------------------------
// Laser line row detector package
// Shared constants, register map and state type of the row detector.
// ----------------------------------------------------------------------------
package llrd_pkg;

    // Default sizes of the line buffer and the range table.
    localparam int MAX_ROW_PIXELS_DEF = 4096;
    localparam int MAX_RANGES_DEF     = 16;

    // Width of the wide configuration registers.
    localparam int CFG_W  = 13;
    localparam int APB_AW = 5;

    // Register map, as word indexes.
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_MAX_WIDTH = 3'd1;
    localparam logic [2:0] REG_MIN_WIDTH = 3'd2;
    localparam logic [2:0] REG_MERGE     = 3'd3;
    localparam logic [2:0] REG_IMG_WIDTH = 3'd4;

    // Reset values of the registers.
    localparam logic [7:0]       THRESHOLD_RST = 8'd20;
    localparam logic [CFG_W-1:0] MAX_WIDTH_RST = 13'd40;
    localparam logic [CFG_W-1:0] MIN_WIDTH_RST = 13'd3;
    localparam logic [CFG_W-1:0] MERGE_RST     = 13'd5;
    localparam logic [CFG_W-1:0] IMG_WIDTH_RST = 13'd640;

    // Saturation limit of the bright pixel count.
    localparam logic [12:0] BRIGHT_MAX = 13'h1FFF;

    typedef enum logic [2:0] {
        ST_STREAM,
        ST_SEL,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

[hw/rtl/llrd_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module llrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/laser_line_row_detector.sv]
// ----------------------------------------------------------------------------
// Laser line row detector
// Finds the laser line in each row and reports its center of mass.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per cycle while a row streams in. When the
// last pixel of a row is taken, input stalls while the end-of-row work runs:
// a scan of the R stored ranges from the range memory, a sum over the W
// pixels of the chosen range from the line memory, the divider, and the load
// of the output register. The result waits in an output register, so the
// next row streams in while it is not yet taken.
`include "laser_line_row_detector_macros.svh"

module laser_line_row_detector #(
    parameter int MAX_ROW_PIXELS = llrd_pkg::MAX_ROW_PIXELS_DEF,
    parameter int MAX_RANGES     = llrd_pkg::MAX_RANGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Pixel input: on_gray [7:0], off_gray [15:8].
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,
    input  logic                       s_axis_tlast,
    // Pixel flags: last_in_frame [0].
    input  logic                       s_axis_tuser,
    // Row result: center_column [11:0], range_first [23:12],
    // range_after [36:24], ranges_in_row [41:37], ranges_overflowed [42],
    // bright_pixels [55:43].
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [55:0]                m_axis_tdata,
    // Row flags: laser_found [0].
    output logic                       m_axis_tuser,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [llrd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import llrd_pkg::*;

    localparam int ADR_W  = $clog2(MAX_ROW_PIXELS);
    localparam int CNT_W  = $clog2(MAX_ROW_PIXELS + 1);
    localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam int RI_W   = $clog2(MAX_RANGES);
    localparam int RC_W   = $clog2(MAX_RANGES + 1);
    localparam int RNG_W  = ADR_W + CNT_W;
    localparam int TOT_W  = 8 + CNT_W;
    localparam int WGT_W  = 8 + 2 * CNT_W;
    localparam int NUM_W  = WGT_W + 2;
    localparam int STEP_W = $clog2(CNT_W + 1);

    // Configuration registers.
    logic [7:0]       r_thr;
    logic [CFG_W-1:0] r_max_w;
    logic [CFG_W-1:0] r_min_w;
    logic [CFG_W-1:0] r_merge;
    logic [CFG_W-1:0] r_img_w;

    // Control state.
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_col;
    logic             r_run_open;
    logic [ADR_W-1:0] r_open_start;
    logic [RC_W-1:0]  r_count;
    logic [ADR_W-1:0] r_last_start;
    logic [CNT_W-1:0] r_last_end;
    logic [12:0]      r_bright;
    logic             r_ovf;
    logic             r_frame_end;
    logic             r_first_row;
    logic [11:0]      r_prev;

    // Range selection.
    logic [RC_W-1:0]  r_idx;
    logic             r_dv;
    logic             r_have;
    logic [CMP_W-1:0] r_bdist;
    logic [ADR_W-1:0] r_best_s;
    logic [CNT_W-1:0] r_best_e;

    // Centroid sums and division.
    logic [CNT_W-1:0] r_j;
    logic             r_p1_v;
    logic [CNT_W-1:0] r_p1_off;
    logic             r_p2_v;
    logic [7:0]       r_p2_d;
    logic [WGT_W-1:0] r_prod;
    logic [TOT_W-1:0] r_tot;
    logic [WGT_W-1:0] r_wgt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [CNT_W-1:0] r_q;
    logic [STEP_W-1:0] r_step;

    // Output register.
    logic             r_ov;
    logic             r_o_found;
    logic [55:0]      r_o_data;

    // Memory ports.
    logic [7:0]       diff_rd;
    logic [ADR_W-1:0] diff_raddr;
    logic             rng_we;
    logic [RI_W-1:0]  rng_waddr;
    logic [RNG_W-1:0] rng_wdata;
    logic [RI_W-1:0]  rng_raddr;
    logic [RNG_W-1:0] rng_rd;

    // Combinational helpers.
    logic             in_take;
    logic             row_end;
    logic [7:0]       diff;
    logic             col_ok;
    logic             bright;
    logic             close_run;
    logic [CNT_W-1:0] run_w;
    logic             w_ok;
    logic [CMP_W-1:0] gap;
    logic             merge;
    logic [ADR_W-1:0] rd_s;
    logic [CNT_W-1:0] rd_e;
    logic [CMP_W-1:0] rd_mid;
    logic [CMP_W-1:0] ref_col;
    logic [CMP_W-1:0] mid_diff;
    logic             sel_done;
    logic             sum_issue;
    logic             sum_done;
    logic             out_free;
    logic             cfg_wr;
    logic [CMP_W-1:0] best_mid;
    logic [CMP_W-1:0] center;
    logic [7:0]       cnt_x;
    logic [4:0]       cnt_sat;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THRESHOLD_RST;
            r_max_w <= MAX_WIDTH_RST;
            r_min_w <= MIN_WIDTH_RST;
            r_merge <= MERGE_RST;
            r_img_w <= IMG_WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_THRESHOLD: r_thr   <= pwdata[7:0];
                REG_MAX_WIDTH: r_max_w <= pwdata[CFG_W-1:0];
                REG_MIN_WIDTH: r_min_w <= pwdata[CFG_W-1:0];
                REG_MERGE:     r_merge <= pwdata[CFG_W-1:0];
                REG_IMG_WIDTH: r_img_w <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_THRESHOLD: prdata = {24'd0, r_thr};
            REG_MAX_WIDTH: prdata = {19'd0, r_max_w};
            REG_MIN_WIDTH: prdata = {19'd0, r_min_w};
            REG_MERGE:     prdata = {19'd0, r_merge};
            REG_IMG_WIDTH: prdata = {19'd0, r_img_w};
            default:       prdata = 32'd0;
        endcase
    end

    // Pixel stream: difference, run detection and range closing.
    assign in_take   = s_axis_tvalid & s_axis_tready;
    assign row_end   = s_axis_tlast | s_axis_tuser;
    assign diff      = (s_axis_tdata[7:0] > s_axis_tdata[15:8]) ?
                       (s_axis_tdata[7:0] - s_axis_tdata[15:8]) : 8'd0;
    assign col_ok    = r_col < CNT_W'(MAX_ROW_PIXELS);
    assign bright    = diff > r_thr;
    assign close_run = in_take & col_ok & ~bright & r_run_open;
    assign run_w     = r_col - CNT_W'(r_open_start);
    assign w_ok      = (CMP_W'(run_w) <= CMP_W'(r_max_w)) &&
                       (CMP_W'(run_w) >= CMP_W'(r_min_w));
    assign gap       = CMP_W'(r_open_start) - CMP_W'(r_last_end);
    assign merge     = (r_count != '0) && (gap < CMP_W'(r_merge));
    assign rng_we    = close_run & w_ok & (merge | (r_count < RC_W'(MAX_RANGES)));
    assign rng_waddr = merge ? RI_W'(r_count - RC_W'(1)) : RI_W'(r_count);
    assign rng_wdata = {merge ? r_last_start : r_open_start, r_col};

    // Range scan: distance of each midpoint to the tracking column.
    assign rd_s     = rng_rd[RNG_W-1:CNT_W];
    assign rd_e     = rng_rd[CNT_W-1:0];
    assign rd_mid   = (CMP_W'(rd_s) + CMP_W'(rd_e)) >> 1;
    assign ref_col  = r_first_row ? CMP_W'(r_img_w[CFG_W-1:1]) : CMP_W'(r_prev);
    assign mid_diff = (rd_mid > ref_col) ? (rd_mid - ref_col) : (ref_col - rd_mid);
    assign sel_done = (r_idx == r_count) && !r_dv;

    // Centroid sweep over the chosen range.
    assign sum_issue = r_j < r_best_e;
    assign sum_done  = !sum_issue && !r_p1_v && !r_p2_v;

    // Result fields.
    assign out_free = !r_ov || m_axis_tready;
    assign best_mid = (CMP_W'(r_best_s) + CMP_W'(r_best_e)) >> 1;
    assign center   = (r_tot == '0) ? CMP_W'(r_best_s) :
                      (CMP_W'(r_best_s) + CMP_W'(r_q));
    assign cnt_x    = 8'(r_count);
    assign cnt_sat  = (cnt_x > 8'd31) ? 5'd31 : cnt_x[4:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_STREAM: if (in_take && row_end) n_state = ST_SEL;
            ST_SEL:    if (sel_done) n_state = r_have ? ST_SUM : ST_EMIT;
            ST_SUM:    if (sum_done) n_state = ST_DIV;
            ST_DIV:    if (r_step == STEP_W'(CNT_W - 1)) n_state = ST_EMIT;
            ST_EMIT:   if (out_free) n_state = ST_STREAM;
            default:   n_state = ST_STREAM;
        endcase
    end

    // State outputs: input ready and memory read addresses.
    always_comb begin
        s_axis_tready = 1'b0;
        diff_raddr    = r_j[ADR_W-1:0];
        rng_raddr     = r_idx[RI_W-1:0];
        unique case (r_state)
            ST_STREAM: s_axis_tready = 1'b1;
            ST_SEL, ST_SUM, ST_DIV, ST_EMIT: s_axis_tready = 1'b0;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_STREAM;
            r_col        <= '0;
            r_run_open   <= 1'b0;
            r_count      <= '0;
            r_bright     <= '0;
            r_ovf        <= 1'b0;
            r_frame_end  <= 1'b0;
            r_first_row  <= 1'b1;
            r_prev       <= '0;
            r_idx        <= '0;
            r_dv         <= 1'b0;
            r_have       <= 1'b0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            // A taken result frees the output register unless a new one loads.
            if (m_axis_tready && !((r_state == ST_EMIT) && out_free)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_STREAM: begin
                    if (in_take && col_ok) begin
                        r_col <= r_col + CNT_W'(1);
                        if (bright) begin
                            if (r_bright != BRIGHT_MAX) begin
                                r_bright <= r_bright + 13'd1;
                            end
                            if (!r_run_open) begin
                                r_run_open   <= 1'b1;
                                r_open_start <= r_col[ADR_W-1:0];
                            end
                        end else if (r_run_open) begin
                            r_run_open <= 1'b0;
                        end
                    end
                    if (close_run && w_ok) begin
                        if (merge) begin
                            r_last_end <= r_col;
                        end else if (r_count < RC_W'(MAX_RANGES)) begin
                            r_last_start <= r_open_start;
                            r_last_end   <= r_col;
                            r_count      <= r_count + RC_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    if (in_take && row_end) begin
                        r_frame_end <= s_axis_tuser;
                        r_idx       <= '0;
                        r_dv        <= 1'b0;
                        r_have      <= 1'b0;
                    end
                end
                ST_SEL: begin
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + RC_W'(1);
                        r_dv  <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv && (!r_have || mid_diff < r_bdist)) begin
                        r_have   <= 1'b1;
                        r_bdist  <= mid_diff;
                        r_best_s <= rd_s;
                        r_best_e <= rd_e;
                    end
                    if (sel_done) begin
                        r_j    <= CNT_W'(r_best_s);
                        r_tot  <= '0;
                        r_wgt  <= '0;
                        r_p1_v <= 1'b0;
                        r_p2_v <= 1'b0;
                    end
                end
                ST_SUM: begin
                    if (sum_issue) begin
                        r_j <= r_j + CNT_W'(1);
                    end
                    r_p1_v   <= sum_issue;
                    r_p1_off <= r_j - CNT_W'(r_best_s);
                    r_p2_v   <= r_p1_v;
                    r_p2_d   <= diff_rd;
                    r_prod   <= WGT_W'(diff_rd) * WGT_W'(r_p1_off);
                    if (r_p2_v) begin
                        r_tot <= r_tot + TOT_W'(r_p2_d);
                        r_wgt <= r_wgt + r_prod;
                    end
                    if (sum_done) begin
                        r_rem  <= {r_wgt, 1'b0} + NUM_W'(r_tot);
                        r_den  <= NUM_W'(r_tot) << CNT_W;
                        r_q    <= '0;
                        r_step <= '0;
                    end
                end
                ST_DIV: begin
                    // One quotient bit per cycle, restoring form.
                    if (r_rem >= r_den) begin
                        r_rem <= r_rem - r_den;
                        r_q   <= {r_q[CNT_W-2:0], 1'b1};
                    end else begin
                        r_q <= {r_q[CNT_W-2:0], 1'b0};
                    end
                    r_den  <= r_den >> 1;
                    r_step <= r_step + STEP_W'(1);
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ov      <= 1'b1;
                        r_o_found <= r_have;
                        r_o_data  <= {r_bright, r_ovf, cnt_sat,
                                      r_have ? 13'(r_best_e) : 13'd0,
                                      r_have ? 12'(r_best_s) : 12'd0,
                                      r_have ? center[11:0] : 12'd0};
                        if (r_have) begin
                            r_prev      <= best_mid[11:0];
                            r_first_row <= 1'b0;
                        end
                        if (r_frame_end) begin
                            r_first_row <= 1'b1;
                        end
                        r_col      <= '0;
                        r_run_open <= 1'b0;
                        r_count    <= '0;
                        r_bright   <= '0;
                        r_ovf      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_found;

    // Line buffer of pixel differences.
    llrd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_ROW_PIXELS)
    ) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (in_take & col_ok),
        .i_waddr (r_col[ADR_W-1:0]),
        .i_wdata (diff),
        .i_raddr (diff_raddr),
        .o_rdata (diff_rd)
    );

    // Range table: start column and column after the end of each stored range.
    llrd_ram #(
        .WIDTH(RNG_W),
        .DEPTH(MAX_RANGES)
    ) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (rng_we),
        .i_waddr (rng_waddr),
        .i_wdata (rng_wdata),
        .i_raddr (rng_raddr),
        .o_rdata (rng_rd)
    );

    // Checks.
    `LLRD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= RC_W'(MAX_RANGES), "range count beyond table size")
    `LLRD_ASSERT_IMPL(a_col_bound, i_clk, i_rst_n, 1'b1,
        r_col <= CNT_W'(MAX_ROW_PIXELS), "column counter beyond line buffer")
    `LLRD_ASSERT_NEXT(a_row_end_stall, i_clk, i_rst_n, in_take && row_end,
        !s_axis_tready, "input not stalled after row end")
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Laser line row detector testbench
// Streams rows of laser-on/laser-off pixel pairs through the detector and
// checks every row result against a cycle-free predictor of the row logic,
// over several register settings and with random idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import llrd_pkg::*;

    localparam int LINE_PIXELS = 4096;
    localparam int TABLE_SIZE  = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 3000;

    // One row result, as carried on the output stream.
    typedef struct packed {
        bit        found;
        bit [11:0] center;
        bit [11:0] first;
        bit [12:0] after;
        bit [4:0]  n_ranges;
        bit        overflow;
        bit [12:0] bright;
    } row_result_t;

    // Predicts the row results from the accepted pixels and checks them.
    class row_scoreboard;
        bit [7:0]    thresh;
        int unsigned max_w, min_w, merge_d, img_w;
        bit [7:0]    diff_mem[LINE_PIXELS];
        int unsigned rng_first[TABLE_SIZE];
        int unsigned rng_after[TABLE_SIZE];
        int unsigned n_ranges;
        bit          run_active;
        int unsigned run_first;
        int unsigned col;
        int unsigned track_col;
        bit          frame_start;
        int unsigned n_bright;
        bit          table_full;
        row_result_t pending[$];
        int          errors;

        function new();
            thresh      = THRESHOLD_RST;
            max_w       = MAX_WIDTH_RST;
            min_w       = MIN_WIDTH_RST;
            merge_d     = MERGE_RST;
            img_w       = IMG_WIDTH_RST;
            track_col   = 0;
            frame_start = 1'b1;
            errors      = 0;
            clear_row();
        endfunction

        function void clear_row();
            n_ranges   = 0;
            run_active = 1'b0;
            run_first  = 0;
            col        = 0;
            n_bright   = 0;
            table_full = 1'b0;
        endfunction

        // A run ends at column c: keep it, merge it or drop it.
        function void end_run(int unsigned c);
            int unsigned w;
            w = c - run_first;
            run_active = 1'b0;
            if (w > max_w || w < min_w)
                return;
            if (n_ranges > 0 && run_first - rng_after[n_ranges-1] < merge_d) begin
                rng_after[n_ranges-1] = c;
                return;
            end
            if (n_ranges < TABLE_SIZE) begin
                rng_first[n_ranges] = run_first;
                rng_after[n_ranges] = c;
                n_ranges++;
            end else begin
                table_full = 1'b1;
            end
        endfunction

        function void note_pixel(bit [7:0] on_v, bit [7:0] off_v, bit row_end,
                                 bit frame_end);
            bit [7:0]          d;
            row_result_t       res;
            int unsigned       target, best, best_dist, mid, spread, s, e;
            longint unsigned   total, weighted, offs;
            if (col < LINE_PIXELS) begin
                d = (on_v > off_v) ? on_v - off_v : 8'd0;
                diff_mem[col] = d;
                if (d > thresh) begin
                    if (n_bright < 8191)
                        n_bright++;
                    if (!run_active) begin
                        run_active = 1'b1;
                        run_first  = col;
                    end
                end else if (run_active) begin
                    end_run(col);
                end
                col++;
            end
            if (!row_end && !frame_end)
                return;
            res = '0;
            if (n_ranges > 0) begin
                target    = frame_start ? (img_w >> 1) : track_col;
                best      = 0;
                best_dist = 32'hFFFF_FFFF;
                for (int i = 0; i < n_ranges; i++) begin
                    mid    = (rng_first[i] + rng_after[i]) >> 1;
                    spread = (mid > target) ? mid - target : target - mid;
                    if (spread < best_dist) begin
                        best_dist = spread;
                        best      = i;
                    end
                end
                s        = rng_first[best];
                e        = rng_after[best];
                total    = 0;
                weighted = 0;
                offs     = 0;
                for (int unsigned j = s; j < e && j < LINE_PIXELS; j++) begin
                    total    += diff_mem[j];
                    weighted += longint'(diff_mem[j]) * (j - s);
                end
                if (total != 0)
                    offs = (2 * weighted + total) / (2 * total);
                res.found   = 1'b1;
                res.center  = 12'(s + offs);
                res.first   = 12'(s);
                res.after   = 13'(e);
                track_col   = ((s + e) >> 1) & 12'hFFF;
                frame_start = 1'b0;
            end
            res.n_ranges = (n_ranges > 31) ? 5'd31 : 5'(n_ranges);
            res.overflow = table_full;
            res.bright   = 13'(n_bright);
            pending.push_back(res);
            clear_row();
            if (frame_end)
                frame_start = 1'b1;
        endfunction

        function void check_row(row_result_t got);
            row_result_t want;
            if (pending.size() == 0) begin
                $error("row result with none expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.found != want.found) begin
                $error("laser_found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.center != want.center) begin
                $error("center_column: expected %0d, got %0d", want.center, got.center);
                errors++;
            end
            if (got.first != want.first) begin
                $error("range_first: expected %0d, got %0d", want.first, got.first);
                errors++;
            end
            if (got.after != want.after) begin
                $error("range_after: expected %0d, got %0d", want.after, got.after);
                errors++;
            end
            if (got.n_ranges != want.n_ranges) begin
                $error("ranges_in_row: expected %0d, got %0d", want.n_ranges,
                       got.n_ranges);
                errors++;
            end
            if (got.overflow != want.overflow) begin
                $error("ranges_overflowed: expected %0d, got %0d", want.overflow,
                       got.overflow);
                errors++;
            end
            if (got.bright != want.bright) begin
                $error("bright_pixels: expected %0d, got %0d", want.bright, got.bright);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    row_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    laser_line_row_detector uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check each transaction, then choose the next ready.
    always @(posedge i_clk) begin
        row_result_t got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.found    = m_axis_tuser;
            got.center   = m_axis_tdata[11:0];
            got.first    = m_axis_tdata[23:12];
            got.after    = m_axis_tdata[36:24];
            got.n_ranges = m_axis_tdata[41:37];
            got.overflow = m_axis_tdata[42];
            got.bright   = m_axis_tdata[55:43];
            sb.check_row(got);
        end
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_THRESHOLD: sb.thresh  = value[7:0];
            REG_MAX_WIDTH: sb.max_w   = value[12:0];
            REG_MIN_WIDTH: sb.min_w   = value[12:0];
            REG_MERGE:     sb.merge_d = value[12:0];
            REG_IMG_WIDTH: sb.img_w   = value[12:0];
            default: ;
        endcase
    endtask

    // Offer one pixel, with random idle cycles ahead of it.
    task automatic send_pixel(input bit [7:0] on_v, input bit [7:0] off_v,
                              input bit row_end, input bit frame_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {off_v, on_v};
        s_axis_tlast  <= row_end;
        s_axis_tuser  <= frame_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pixel(on_v, off_v, row_end, frame_end);
    endtask

    // One row: runs of bright and dark pixels, or pure noise.
    task automatic send_row(input int len, input bit noisy, input int max_seg);
        bit [7:0] on_v, off_v;
        int       seg_left, d, lo;
        bit       lit, frame_end, row_end;
        seg_left  = 0;
        lit       = ($urandom_range(1) != 0);
        frame_end = ($urandom_range(3) == 0);
        for (int p = 0; p < len; p++) begin
            if (noisy) begin
                on_v  = 8'($urandom_range(255));
                off_v = 8'($urandom_range(255));
            end else begin
                if (seg_left == 0) begin
                    lit      = !lit;
                    seg_left = $urandom_range(max_seg, 1);
                end
                seg_left--;
                if (lit && sb.thresh < 255) begin
                    d     = $urandom_range(255, sb.thresh + 1);
                    off_v = 8'($urandom_range(255 - d));
                    on_v  = 8'(off_v + d);
                end else begin
                    on_v  = 8'($urandom_range(255));
                    lo    = (on_v > sb.thresh) ? on_v - sb.thresh : 0;
                    off_v = 8'($urandom_range(255, lo));
                end
            end
            row_end = (p == len - 1);
            // The frame flag alone also ends a row.
            send_pixel(on_v, off_v, row_end && !(frame_end && $urandom_range(1)),
                       row_end && frame_end);
        end
    endtask

    // Wait until every expected row has come and the block is at rest.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    initial begin
        int rows, len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed row at reset settings: kept run, short run dropped,
        // a value at the threshold, and a run left open at the row end.
        send_pixel(8'd255, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd200, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd21, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd21, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd20, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd90, 8'd10, 1'b0, 1'b0);
        send_pixel(8'd91, 8'd10, 1'b0, 1'b0);
        send_pixel(8'd92, 8'd10, 1'b1, 1'b0);
        // Row with no range, then a frame end with a kept run.
        send_pixel(8'd5, 8'd5, 1'b1, 1'b0);
        send_pixel(8'd100, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd100, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd100, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 1'b0, 1'b1);
        // A single-pixel row.
        send_pixel(8'd255, 8'd255, 1'b1, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_THRESHOLD, 0);
                    write_reg(REG_MAX_WIDTH, 4096);
                    write_reg(REG_MIN_WIDTH, 1);
                    write_reg(REG_MERGE, 0);
                    write_reg(REG_IMG_WIDTH, 1);
                end
                1: begin
                    write_reg(REG_MERGE, 4096);
                    write_reg(REG_IMG_WIDTH, 4096);
                end
                2: begin
                    write_reg(REG_THRESHOLD, 255);
                end
                3: begin
                    write_reg(REG_THRESHOLD, 30);
                    write_reg(REG_MIN_WIDTH, 10);
                    write_reg(REG_MAX_WIDTH, 5);
                end
                4: begin
                    write_reg(REG_THRESHOLD, 20);
                    write_reg(REG_MIN_WIDTH, 3);
                    write_reg(REG_MAX_WIDTH, 40);
                    write_reg(REG_MERGE, 5);
                    write_reg(REG_IMG_WIDTH, 40);
                end
                5: begin
                    write_reg(REG_MIN_WIDTH, 1);
                    write_reg(REG_MAX_WIDTH, 2);
                    write_reg(REG_MERGE, 1);
                end
                6: begin
                    write_reg(REG_THRESHOLD, $urandom_range(200));
                    write_reg(REG_MIN_WIDTH, $urandom_range(4, 1));
                    write_reg(REG_MAX_WIDTH, $urandom_range(30, 4));
                    write_reg(REG_MERGE, $urandom_range(8));
                    write_reg(REG_IMG_WIDTH, $urandom_range(64, 1));
                end
                default: begin
                    write_reg(REG_THRESHOLD, 10);
                    write_reg(REG_MIN_WIDTH, 2);
                    write_reg(REG_MAX_WIDTH, 12);
                    write_reg(REG_MERGE, 3);
                    write_reg(REG_IMG_WIDTH, 25);
                end
            endcase
            set_idle_mode(phase % 4);
            // Long receiver hold-off so that the block fills up.
            if (phase == 4)
                hold_req = hold_req + 1;
            rows = 0;
            while (rows < 6) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(3, 1)
                                               : $urandom_range(40, 4);
                send_row(len, ($urandom_range(4) == 0), (phase < 2) ? 2 : 10);
                rows++;
            end
            drain();
        end

        // Longer random stretch over all idle modes at a typical setting.
        write_reg(REG_THRESHOLD, 20);
        write_reg(REG_MIN_WIDTH, 2);
        write_reg(REG_MAX_WIDTH, 16);
        write_reg(REG_MERGE, 4);
        write_reg(REG_IMG_WIDTH, 30);
        for (int blk = 0; blk < 4; blk++) begin
            set_idle_mode(blk);
            for (int r = 0; r < 3; r++)
                send_row($urandom_range(40, 1), ($urandom_range(5) == 0), 8);
        end
        drain();

        if (sb.pending.size() != 0) begin
            $error("%0d row results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[laser_line_row_detector.f]
+incdir+hw/rtl
hw/rtl/llrd_pkg.sv
hw/rtl/llrd_ram.sv
hw/rtl/laser_line_row_detector.sv
test/tb_top.sv
